[hdl/wpcf_pkg.sv]
`timescale 1ns / 1ps

package wpcf_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int KEY_COLUMNS_DEF = 4;

    localparam int DATE_W       = 32;
    localparam int ID_W         = 16;
    localparam int KEY_W        = 16;
    localparam int KCU_W        = 3;
    localparam int ROW_W        = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // stored entry layout: date, person id, event id, then key columns from column 0 up
    localparam int ENTRY_PID_LSB = DATE_W;
    localparam int ENTRY_EID_LSB = DATE_W + ID_W;
    localparam int ENTRY_KEY_LSB = DATE_W + 2 * ID_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DATE_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLS    = 1'b1;

    localparam logic [KCU_W-1:0] KCU_RESET = 3'd4;

    typedef struct packed {
        logic                     start_new_set;
        logic signed [DATE_W-1:0] row_date;
        logic [ID_W-1:0]          person_id;
        logic [ID_W-1:0]          event_id;
        logic [KEY_W-1:0]         key_a;
        logic [KEY_W-1:0]         key_b;
        logic [KEY_W-1:0]         key_c;
        logic [KEY_W-1:0]         key_d;
    } t_in_beat;

    typedef struct packed {
        logic [ROW_W-1:0] row_number;
        logic [ROW_W-1:0] partner_number;
        logic             has_partner;
        logic             last_of_run;
        logic             store_full;
    } t_out_beat;

    typedef struct packed {
        logic [DATE_W-1:0] date_window;
        logic [KCU_W-1:0]  key_columns_used;
    } t_cfg;

endpackage

[hdl/wpcf_store.sv]
`timescale 1ns / 1ps

module wpcf_store #(
    parameter int ENTRIES = wpcf_pkg::MAX_ROWS_DEF,
    parameter int DW      = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [DW-1:0]              i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [DW-1:0]              o_rdata
);

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/wpcf_cmp.sv]
`timescale 1ns / 1ps

module wpcf_cmp #(
    parameter int KEY_COLUMNS = wpcf_pkg::KEY_COLUMNS_DEF,
    parameter int DW          = wpcf_pkg::ENTRY_KEY_LSB + KEY_COLUMNS * wpcf_pkg::KEY_W
) (
    input  wpcf_pkg::t_cfg i_cfg,
    input  logic [DW-1:0]  i_row,
    input  logic [DW-1:0]  i_stored,
    output logic           o_hit
);

    localparam int DATE_W = wpcf_pkg::DATE_W;
    localparam int ID_W   = wpcf_pkg::ID_W;
    localparam int KEY_W  = wpcf_pkg::KEY_W;
    localparam int KCU_W  = wpcf_pkg::KCU_W;
    localparam int PID_L  = wpcf_pkg::ENTRY_PID_LSB;
    localparam int EID_L  = wpcf_pkg::ENTRY_EID_LSB;
    localparam int KEY_L  = wpcf_pkg::ENTRY_KEY_LSB;

    logic signed [DATE_W:0] date_a;
    logic signed [DATE_W:0] date_b;
    logic signed [DATE_W:0] diff;
    logic [DATE_W:0]        abs_diff;
    logic                   date_ok;
    logic                   ids_ok;
    logic [KCU_W-1:0]       kc_eff;
    logic [KEY_COLUMNS-1:0] key_miss;

    // 33-bit difference of two signed dates never overflows
    always_comb begin
        date_a   = {i_row[DATE_W-1], i_row[DATE_W-1:0]};
        date_b   = {i_stored[DATE_W-1], i_stored[DATE_W-1:0]};
        diff     = date_a - date_b;
        abs_diff = diff[DATE_W] ? (DATE_W+1)'(-diff) : diff;
        date_ok  = abs_diff <= {1'b0, i_cfg.date_window};
    end

    assign ids_ok = (i_row[PID_L +: ID_W] != i_stored[PID_L +: ID_W])
                 && (i_row[EID_L +: ID_W] != i_stored[EID_L +: ID_W]);

    assign kc_eff = (i_cfg.key_columns_used > KCU_W'(KEY_COLUMNS))
                  ? KCU_W'(KEY_COLUMNS) : i_cfg.key_columns_used;

    always_comb begin
        for (int k = 0; k < KEY_COLUMNS; k++) begin
            key_miss[k] = (KCU_W'(k) < kc_eff)
                && (i_row[KEY_L + k * KEY_W +: KEY_W] != i_stored[KEY_L + k * KEY_W +: KEY_W]);
        end
    end

    assign o_hit = ids_ok && date_ok && !(|key_miss);

endmodule

[hdl/windowed_pair_candidate_finder_unit.sv]
`timescale 1ns / 1ps

// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------
// in       | i_in_valid  | o_in_stall  | i_in_data  (t_in_beat)
// out      | o_out_valid | i_out_stall | o_out_data (t_out_beat)
// cfg      | i_cfg_we    | -           | i_cfg_index, i_cfg_wdata
//
// a row at store position n passes through accept, n reads of the store through one
// shared compare unit plus one drain step, final beat
// a full-store row skips the scan; the store's single read port sets the scan rate
// synchronous active-low reset clears the row count, config and control state
// the store contents have no reset; only positions below the row count are read
// a stalled output holds the scan when a second partner is found before the first leaves

module windowed_pair_candidate_finder_unit #(
    parameter int MAX_ROWS    = wpcf_pkg::MAX_ROWS_DEF,
    parameter int KEY_COLUMNS = wpcf_pkg::KEY_COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  wpcf_pkg::t_in_beat                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output wpcf_pkg::t_out_beat                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [wpcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpcf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW     = $clog2(MAX_ROWS);
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int KEY_W  = wpcf_pkg::KEY_W;
    localparam int KEY_L  = wpcf_pkg::ENTRY_KEY_LSB;
    localparam int EW     = KEY_L + KEY_COLUMNS * KEY_W;
    localparam int ROW_W  = wpcf_pkg::ROW_W;
    localparam int KCU_W  = wpcf_pkg::KCU_W;
    localparam int DATE_W = wpcf_pkg::DATE_W;
    localparam int ID_W   = wpcf_pkg::ID_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    wpcf_pkg::t_cfg      r_cfg, n_cfg;
    logic [RCW-1:0]      r_rows, n_rows;
    logic [RCW-1:0]      r_idx, n_idx;
    logic                r_full, n_full;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_pend_vld, n_pend_vld;
    logic                r_o_valid, n_o_valid;
    logic [AW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic [EW-1:0]       r_row_entry, n_row_entry;
    wpcf_pkg::t_out_beat r_o_data, n_o_data;

    logic [KEY_W-1:0] keys_in [4];
    logic [EW-1:0]    in_entry;
    logic [EW-1:0]    rd_data;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [RCW-1:0]   cnt_eff;
    logic             full_eff;
    logic             cmp_hit;
    logic             match;
    logic             out_free;
    logic             hold;

    assign keys_in[0] = i_in_data.key_a;
    assign keys_in[1] = i_in_data.key_b;
    assign keys_in[2] = i_in_data.key_c;
    assign keys_in[3] = i_in_data.key_d;

    assign in_entry[DATE_W-1:0]                           = i_in_data.row_date;
    assign in_entry[wpcf_pkg::ENTRY_PID_LSB +: ID_W]      = i_in_data.person_id;
    assign in_entry[wpcf_pkg::ENTRY_EID_LSB +: ID_W]      = i_in_data.event_id;

    for (genvar k = 0; k < KEY_COLUMNS; k++) begin : g_keys
        assign in_entry[KEY_L + k * KEY_W +: KEY_W] = keys_in[k];
    end

    wpcf_store #(
        .ENTRIES (MAX_ROWS),
        .DW      (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (in_entry),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    wpcf_cmp #(
        .KEY_COLUMNS (KEY_COLUMNS),
        .DW          (EW)
    ) u_cmp (
        .i_cfg    (r_cfg),
        .i_row    (r_row_entry),
        .i_stored (rd_data),
        .o_hit    (cmp_hit)
    );

    assign cnt_eff  = i_in_data.start_new_set ? '0 : r_rows;
    assign full_eff = (cnt_eff == RCW'(MAX_ROWS));
    assign wr_addr  = cnt_eff[AW-1:0];
    assign out_free = !r_o_valid || !i_out_stall;
    assign match    = r_cmp_vld && cmp_hit;
    // a second partner cannot displace the held one until the output slot frees
    assign hold     = match && r_pend_vld && !out_free;

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_rows      = r_rows;
        n_idx       = r_idx;
        n_full      = r_full;
        n_cmp_vld   = r_cmp_vld;
        n_pend_vld  = r_pend_vld;
        n_row       = r_row;
        n_cmp_idx   = r_cmp_idx;
        n_pend_idx  = r_pend_idx;
        n_row_entry = r_row_entry;
        n_o_valid   = r_o_valid && i_out_stall;
        n_o_data    = r_o_data;
        rd_en       = 1'b0;
        wr_en       = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wpcf_pkg::CFG_DATE_WINDOW: n_cfg.date_window = i_cfg_wdata;
                wpcf_pkg::CFG_KEY_COLS:    n_cfg.key_columns_used = i_cfg_wdata[KCU_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_row_entry = in_entry;
                    n_pend_vld  = 1'b0;
                    n_cmp_vld   = 1'b0;
                    n_idx       = '0;
                    if (full_eff) begin
                        n_full  = 1'b1;
                        n_row   = '0;
                        n_rows  = cnt_eff;
                        n_state = ST_DONE;
                    end else begin
                        // the new row's slot lies past every position the scan reads
                        wr_en   = 1'b1;
                        n_full  = 1'b0;
                        n_row   = cnt_eff[AW-1:0];
                        n_rows  = cnt_eff + RCW'(1);
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!hold) begin
                    if (match) begin
                        if (r_pend_vld) begin
                            n_o_valid                = 1'b1;
                            n_o_data.row_number      = ROW_W'(r_row);
                            n_o_data.partner_number  = ROW_W'(r_pend_idx);
                            n_o_data.has_partner     = 1'b1;
                            n_o_data.last_of_run     = 1'b0;
                            n_o_data.store_full      = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_cmp_idx;
                    end
                    if (r_idx < RCW'(r_row)) begin
                        rd_en     = 1'b1;
                        n_cmp_vld = 1'b1;
                        n_cmp_idx = r_idx[AW-1:0];
                        n_idx     = r_idx + RCW'(1);
                    end else begin
                        n_cmp_vld = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid               = 1'b1;
                    n_o_data.row_number     = ROW_W'(r_row);
                    n_o_data.partner_number = r_pend_vld ? ROW_W'(r_pend_idx) : '0;
                    n_o_data.has_partner    = r_pend_vld;
                    n_o_data.last_of_run    = 1'b1;
                    n_o_data.store_full     = r_full;
                    n_pend_vld              = 1'b0;
                    n_state                 = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                <= ST_IDLE;
            r_cfg.date_window      <= '0;
            r_cfg.key_columns_used <= wpcf_pkg::KCU_RESET;
            r_rows                 <= '0;
            r_idx                  <= '0;
            r_full                 <= 1'b0;
            r_cmp_vld              <= 1'b0;
            r_pend_vld             <= 1'b0;
            r_o_valid              <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg      <= n_cfg;
            r_rows     <= n_rows;
            r_idx      <= n_idx;
            r_full     <= n_full;
            r_cmp_vld  <= n_cmp_vld;
            r_pend_vld <= n_pend_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_cmp_idx   <= n_cmp_idx;
        r_pend_idx  <= n_pend_idx;
        r_row_entry <= n_row_entry;
        r_o_data    <= n_o_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state != ST_IDLE)
        else $error("accepted row did not start a run");

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= RCW'(MAX_ROWS))
        else $error("row count beyond store depth");

    a_no_partner_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.has_partner || o_out_data.last_of_run))
        else $error("no-partner beat not marked last");

    a_pending_below_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld && (r_state == ST_SCAN) |-> r_pend_idx < r_row)
        else $error("held partner not an earlier row");

endmodule

[tb/wpcf_pair_checker.sv]
`timescale 1ns / 1ps

module wpcf_pair_checker #(
    parameter int MAX_ROWS    = wpcf_pkg::MAX_ROWS_DEF,
    parameter int KEY_COLUMNS = wpcf_pkg::KEY_COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  wpcf_pkg::t_in_beat              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  wpcf_pkg::t_out_beat             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [wpcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpcf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_awaited
);

    localparam int DATE_W = wpcf_pkg::DATE_W;
    localparam int ID_W   = wpcf_pkg::ID_W;
    localparam int KEY_W  = wpcf_pkg::KEY_W;
    localparam int KCU_W  = wpcf_pkg::KCU_W;
    localparam int ROW_W  = wpcf_pkg::ROW_W;

    logic signed [DATE_W-1:0] row_dates [MAX_ROWS];
    logic [ID_W-1:0]          row_pids  [MAX_ROWS];
    logic [ID_W-1:0]          row_eids  [MAX_ROWS];
    logic [4*KEY_W-1:0]       row_keys  [MAX_ROWS];
    int unsigned              rows_held;
    logic [DATE_W-1:0]        window;
    logic [KCU_W-1:0]         key_cols;
    wpcf_pkg::t_out_beat      partner_beats_q [$];
    int                       mismatches;

    task automatic add_expected(input wpcf_pkg::t_out_beat b);
        partner_beats_q = {partner_beats_q, b};
    endtask

    // queues a row's beats; a row with room is compared with every held row, then held
    task automatic find_partners(input wpcf_pkg::t_in_beat b);
        logic [4*KEY_W-1:0]     keys;
        logic [4*KEY_W-1:0]     mask;
        logic signed [DATE_W:0] gap;
        logic [DATE_W:0]        span;
        int unsigned            ncols;
        int unsigned            row;
        bit                     have_prev;
        wpcf_pkg::t_out_beat    beat;
        wpcf_pkg::t_out_beat    prev;
        keys = {b.key_d, b.key_c, b.key_b, b.key_a};
        ncols = (key_cols > KEY_COLUMNS) ? KEY_COLUMNS : key_cols;
        mask = '0;
        for (int k = 0; k < ncols; k++) begin
            mask[k*KEY_W +: KEY_W] = '1;
        end
        if (b.start_new_set) begin
            rows_held = 0;
        end
        beat = '0;
        beat.last_of_run = 1'b1;
        if (rows_held >= MAX_ROWS) begin
            beat.store_full = 1'b1;
            add_expected(beat);
            return;
        end
        row = rows_held;
        beat.row_number = ROW_W'(row);
        have_prev = 1'b0;
        prev = '0;
        for (int j = 0; j < row; j++) begin
            // 33-bit difference so the extremes of the date range cannot wrap
            gap = $signed({b.row_date[DATE_W-1], b.row_date})
                - $signed({row_dates[j][DATE_W-1], row_dates[j]});
            span = (gap < 0) ? -gap : gap;
            if (row_pids[j] != b.person_id || row_eids[j] != b.event_id) begin
                if (row_pids[j] != b.person_id && row_eids[j] != b.event_id &&
                    span <= {1'b0, window} && ((row_keys[j] ^ keys) & mask) == '0) begin
                    if (have_prev) begin
                        add_expected(prev);
                    end
                    prev = '0;
                    prev.row_number     = ROW_W'(row);
                    prev.partner_number = ROW_W'(j);
                    prev.has_partner    = 1'b1;
                    have_prev = 1'b1;
                end
            end
        end
        if (have_prev) begin
            prev.last_of_run = 1'b1;
            add_expected(prev);
        end else begin
            add_expected(beat);
        end
        row_dates[row] = b.row_date;
        row_pids[row]  = b.person_id;
        row_eids[row]  = b.event_id;
        row_keys[row]  = keys;
        rows_held = row + 1;
    endtask

    task automatic note_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        wpcf_pkg::t_out_beat want;
        if (!i_rst_n) begin
            rows_held = 0;
            window    = '0;
            key_cols  = wpcf_pkg::KCU_RESET;
            partner_beats_q.delete();
        end else begin
            // results first: a beat leaving now never comes from a row taken now
            if (i_out_valid && !i_out_stall) begin
                if (partner_beats_q.size() == 0) begin
                    $display("%0t: result beat expected none got %p", $time, i_out_data);
                    mismatches++;
                end else begin
                    want = partner_beats_q.pop_front();
                    note_field("row_number", 8'(want.row_number), 8'(i_out_data.row_number));
                    note_field("partner_number", 8'(want.partner_number),
                               8'(i_out_data.partner_number));
                    note_field("has_partner", 8'(want.has_partner), 8'(i_out_data.has_partner));
                    note_field("last_of_run", 8'(want.last_of_run), 8'(i_out_data.last_of_run));
                    note_field("store_full", 8'(want.store_full), 8'(i_out_data.store_full));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wpcf_pkg::CFG_DATE_WINDOW: begin
                        window = i_cfg_wdata[DATE_W-1:0];
                    end
                    wpcf_pkg::CFG_KEY_COLS: begin
                        key_cols = i_cfg_wdata[KCU_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                find_partners(i_in_data);
            end
        end
        o_mismatches <= mismatches;
        o_awaited    <= partner_beats_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ROWS    = wpcf_pkg::MAX_ROWS_DEF;
    localparam int KEY_COLUMNS = wpcf_pkg::KEY_COLUMNS_DEF;
    localparam int DATE_W      = wpcf_pkg::DATE_W;
    localparam int ID_W        = wpcf_pkg::ID_W;
    localparam int KEY_W       = wpcf_pkg::KEY_W;
    localparam int KCU_W       = wpcf_pkg::KCU_W;
    localparam int CFG_IDX_W   = wpcf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = wpcf_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    localparam logic signed [DATE_W-1:0] DATE_MIN = 32'sh8000_0000;
    localparam logic signed [DATE_W-1:0] DATE_MAX = 32'sh7FFF_FFFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    wpcf_pkg::t_in_beat    i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    wpcf_pkg::t_out_beat   o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int mismatches;
    int awaited;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_armed;

    windowed_pair_candidate_finder_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .KEY_COLUMNS (KEY_COLUMNS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    wpcf_pair_checker #(
        .MAX_ROWS    (MAX_ROWS),
        .KEY_COLUMNS (KEY_COLUMNS)
    ) u_pair_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver side: random stalls, plus one long hold-off once armed
    initial begin
        int unsigned held;
        bit          hold_done;
        held = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                if (held < HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    held++;
                end else begin
                    hold_done = 1'b1;
                    i_out_stall <= 1'b0;
                end
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    function automatic wpcf_pkg::t_in_beat make_row(input bit start,
                                                    input logic [DATE_W-1:0] date,
                                                    input int pid, input int eid, input int ka,
                                                    input int kb, input int kc, input int kd);
        wpcf_pkg::t_in_beat b;
        b.start_new_set = start;
        b.row_date      = date;
        b.person_id     = ID_W'(pid);
        b.event_id      = ID_W'(eid);
        b.key_a         = KEY_W'(ka);
        b.key_b         = KEY_W'(kb);
        b.key_c         = KEY_W'(kc);
        b.key_d         = KEY_W'(kd);
        return b;
    endfunction

    // mostly a tiny alphabet so keys collide, now and then any value
    function automatic int pick_key();
        if ($urandom_range(0, 3) != 0) begin
            return $urandom_range(0, 1);
        end
        return $urandom_range(0, 65535);
    endfunction

    task automatic send_row(input wpcf_pkg::t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
    endtask

    task automatic set_config(input logic [DATE_W-1:0] win, input logic [KCU_W-1:0] cols);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= wpcf_pkg::CFG_DATE_WINDOW;
        i_cfg_wdata <= CFG_DATA_W'(win);
        @(posedge i_clk);
        i_cfg_index <= wpcf_pkg::CFG_KEY_COLS;
        i_cfg_wdata <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // short sets of related rows with some noise rows mixed in
    task automatic random_rows(input int n_items, input int spread);
        logic [DATE_W-1:0]  base;
        int                 set_left;
        bit                 first;
        wpcf_pkg::t_in_beat b;
        set_left = 0;
        base = '0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                b = make_row(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
            end else begin
                first = (set_left == 0);
                if (first) begin
                    set_left = $urandom_range(2, 8);
                    base = $urandom;
                end
                b = make_row(first, base + DATE_W'($urandom_range(0, spread)),
                             $urandom_range(0, 3), $urandom_range(0, 3), pick_key(),
                             pick_key(), pick_key(), pick_key());
                set_left--;
            end
            send_row(b);
        end
    endtask

    // one set longer than the store, so the last rows find it full
    task automatic fill_store();
        for (int i = 0; i < MAX_ROWS + 2; i++) begin
            send_row(make_row(i == 0, DATE_W'($urandom_range(0, 40)), $urandom_range(0, 7),
                              $urandom_range(0, 7), pick_key(), pick_key(), pick_key(),
                              pick_key()));
        end
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= wpcf_pkg::CFG_DATE_WINDOW;
        i_cfg_wdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: zero window, all four key columns
        send_row(make_row(1'b1, DATE_MIN, 0, 0, 0, 0, 0, 0));
        send_row(make_row(1'b0, DATE_MIN, 1, 1, 0, 0, 0, 0));
        send_row(make_row(1'b0, DATE_MIN, 0, 2, 0, 0, 0, 0));
        send_row(make_row(1'b0, DATE_MIN, 2, 0, 0, 0, 0, 0));
        send_row(make_row(1'b0, DATE_MAX, 65535, 65535, 65535, 65535, 65535, 65535));
        send_row(make_row(1'b0, DATE_MAX, 0, 1, 65535, 65535, 65535, 65535));

        // widest window spans the whole date range, no key columns
        set_config(32'hFFFF_FFFF, 3'd0);
        send_row(make_row(1'b1, DATE_MIN, 3, 3, 1, 2, 3, 4));
        send_row(make_row(1'b0, DATE_MAX, 4, 4, 5, 6, 7, 8));

        // one short of the full range; column count above the limit
        set_config(32'hFFFF_FFFE, 3'd7);
        send_row(make_row(1'b1, DATE_MAX, 5, 5, 10, 11, 12, 13));
        send_row(make_row(1'b0, DATE_MIN, 6, 6, 10, 11, 12, 13));
        send_row(make_row(1'b0, DATE_MIN + 1, 7, 7, 10, 11, 12, 13));
        send_row(make_row(1'b0, 0, 8, 8, 10, 11, 12, 14));
        set_config(32'hFFFF_FFFE, 3'd3);
        send_row(make_row(1'b0, 0, 9, 9, 10, 11, 12, 15));
        set_config(32'hFFFF_FFFE, 3'd1);
        send_row(make_row(1'b0, 5, 10, 10, 10, 0, 0, 0));

        // window edge across zero
        set_config(100, 3'd2);
        send_row(make_row(1'b1, -50, 1, 1, 0, 0, 0, 0));
        send_row(make_row(1'b0, 50, 2, 2, 0, 0, 9, 9));
        send_row(make_row(1'b0, 151, 3, 3, 0, 0, 0, 0));

        set_config(16, 3'd2);
        random_rows(15, 24);

        send_idle_pct = 53;
        set_config(32'h7FFF_FFFF, 3'd4);
        random_rows(15, 1000);

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        set_config(3, 3'd1);
        random_rows(15, 6);

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        set_config(32'hFFFF_FFFF, 3'd0);
        random_rows(15, 100);

        // long receiver hold-off while the store fills up to full
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(3, 3'd5);
        hold_armed = 1'b1;
        fill_store();

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        set_config(0, 3'd3);
        random_rows(10, 2);

        settle();
        // catch stray beats after the last expected one
        repeat (MAX_ROWS + 8) @(posedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/wpcf_pkg.sv
hdl/wpcf_store.sv
hdl/wpcf_cmp.sv
hdl/windowed_pair_candidate_finder_unit.sv
tb/wpcf_pair_checker.sv
tb/tb_top.sv
